// ===== src/rss_pkg.sv =====
// running sample statistics: shared types, constants and the microprogram
// no dependencies; imported by every other file but rss_if.sv

package rss_pkg;

  localparam int unsigned DATA_W         = 64;
  localparam int unsigned OUT_COUNT_W    = 32;
  localparam int unsigned DIV_RADIX_BITS = 2;
  localparam int unsigned DIV_STEPS      = DATA_W / DIV_RADIX_BITS;
  localparam int unsigned DIV_CNT_W      = $clog2(DIV_STEPS);
  localparam int unsigned PC_W           = 4;

  typedef logic [PC_W-1:0] rss_pc_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_UPDATE,
    OP_MEAN_START,
    OP_MEAN_TAKE,
    OP_MUL_LL,
    OP_MUL_LH,
    OP_SQ_ADD,
    OP_DEV_ACC,
    OP_VAR_START,
    OP_VAR_TAKE,
    OP_EMIT
  } rss_op_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_COUNT_ZERO,
    COND_DIV_BUSY,
    COND_OUT_BLOCKED
  } rss_cond_e;

  typedef struct packed {
    rss_op_e   op;
    rss_cond_e cond;
    rss_pc_t   target;
  } rss_uword_t;

  // sequencer -> datapath
  typedef struct packed {
    rss_op_e op;
    logic    accept;
    logic    emit;
  } rss_ctrl_t;

  // datapath -> sequencer
  typedef struct packed {
    logic in_valid;
    logic count_zero;
    logic div_busy;
    logic out_blocked;
  } rss_status_t;

  // program step addresses
  localparam rss_pc_t STEP_ACCEPT     = 4'd0;
  localparam rss_pc_t STEP_UPDATE     = 4'd1;
  localparam rss_pc_t STEP_BRANCH     = 4'd2;
  localparam rss_pc_t STEP_MEAN_START = 4'd3;
  localparam rss_pc_t STEP_MEAN_WAIT  = 4'd4;
  localparam rss_pc_t STEP_MEAN_TAKE  = 4'd5;
  localparam rss_pc_t STEP_MUL_LL     = 4'd6;
  localparam rss_pc_t STEP_MUL_LH     = 4'd7;
  localparam rss_pc_t STEP_SQ_ADD     = 4'd8;
  localparam rss_pc_t STEP_DEV_ACC    = 4'd9;
  localparam rss_pc_t STEP_VAR_START  = 4'd10;
  localparam rss_pc_t STEP_VAR_WAIT   = 4'd11;
  localparam rss_pc_t STEP_VAR_TAKE   = 4'd12;
  localparam rss_pc_t STEP_EMIT       = 4'd13;
  localparam rss_pc_t STEP_LOOP       = 4'd14;

  // jump to target when cond holds, else fall through
  function automatic rss_uword_t rss_rom(input rss_pc_t pc);
    rss_uword_t w;
    w = '{op: OP_NOP, cond: COND_ALWAYS, target: STEP_ACCEPT};
    case (pc)
      STEP_ACCEPT:     w = '{op: OP_ACCEPT,     cond: COND_NO_INPUT,    target: STEP_ACCEPT};
      STEP_UPDATE:     w = '{op: OP_UPDATE,     cond: COND_NEVER,       target: STEP_ACCEPT};
      STEP_BRANCH:     w = '{op: OP_NOP,        cond: COND_COUNT_ZERO,  target: STEP_EMIT};
      STEP_MEAN_START: w = '{op: OP_MEAN_START, cond: COND_NEVER,       target: STEP_ACCEPT};
      STEP_MEAN_WAIT:  w = '{op: OP_NOP,        cond: COND_DIV_BUSY,    target: STEP_MEAN_WAIT};
      STEP_MEAN_TAKE:  w = '{op: OP_MEAN_TAKE,  cond: COND_NEVER,       target: STEP_ACCEPT};
      STEP_MUL_LL:     w = '{op: OP_MUL_LL,     cond: COND_NEVER,       target: STEP_ACCEPT};
      STEP_MUL_LH:     w = '{op: OP_MUL_LH,     cond: COND_NEVER,       target: STEP_ACCEPT};
      STEP_SQ_ADD:     w = '{op: OP_SQ_ADD,     cond: COND_NEVER,       target: STEP_ACCEPT};
      STEP_DEV_ACC:    w = '{op: OP_DEV_ACC,    cond: COND_NEVER,       target: STEP_ACCEPT};
      STEP_VAR_START:  w = '{op: OP_VAR_START,  cond: COND_NEVER,       target: STEP_ACCEPT};
      STEP_VAR_WAIT:   w = '{op: OP_NOP,        cond: COND_DIV_BUSY,    target: STEP_VAR_WAIT};
      STEP_VAR_TAKE:   w = '{op: OP_VAR_TAKE,   cond: COND_NEVER,       target: STEP_ACCEPT};
      STEP_EMIT:       w = '{op: OP_EMIT,       cond: COND_OUT_BLOCKED, target: STEP_EMIT};
      STEP_LOOP:       w = '{op: OP_NOP,        cond: COND_ALWAYS,      target: STEP_ACCEPT};
      default:         w = '{op: OP_NOP,        cond: COND_ALWAYS,      target: STEP_ACCEPT};
    endcase
    return w;
  endfunction

endpackage

// ===== src/rss_if.sv =====
// transaction channels for the running sample statistics block
// depends on nothing; payload widths are fixed by the field definitions

interface rss_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic signed [63:0] sample;

  modport source (output valid, output opcode, output sample, input ready);
  modport sink   (input valid, input opcode, input sample, output ready);
endinterface

interface rss_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] minimum;
  logic signed [63:0] maximum;
  logic signed [63:0] mean;
  logic        [31:0] sample_count;
  logic        [63:0] squared_deviation_total;
  logic        [63:0] variance;

  modport source (output valid, output minimum, output maximum, output mean,
                  output sample_count, output squared_deviation_total,
                  output variance, input ready);
  modport sink   (input valid, input minimum, input maximum, input mean,
                  input sample_count, input squared_deviation_total,
                  input variance, output ready);
endinterface

// ===== src/rss_divider.sv =====
// iterative unsigned divider, 64-bit dividend by a count-wide divisor
// radix-4 restoring, two quotient bits per cycle; uses rss_pkg

module rss_divider import rss_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [DATA_W-1:0]      dividend_i,
  input  logic [COUNT_WIDTH-1:0] divisor_i,
  output logic                   busy_o,
  output logic [DATA_W-1:0]      quotient_o
);

  logic                   busy_q, busy_d;
  logic [DIV_CNT_W-1:0]   cnt_q, cnt_d;
  logic [COUNT_WIDTH-1:0] rem_q, rem_d;
  logic [DATA_W-1:0]      quo_q, quo_d;
  logic [COUNT_WIDTH-1:0] rem_n;
  logic [DATA_W-1:0]      quo_n;

  // two restoring steps per cycle
  always_comb begin
    logic [COUNT_WIDTH:0] trial;
    logic                 ge;
    rem_n = rem_q;
    quo_n = quo_q;
    for (int i = 0; i < DIV_RADIX_BITS; i++) begin
      trial = {rem_n, quo_n[DATA_W-1]};
      ge    = trial >= {1'b0, divisor_i};
      rem_n = ge ? COUNT_WIDTH'(trial - {1'b0, divisor_i}) : trial[COUNT_WIDTH-1:0];
      quo_n = {quo_n[DATA_W-2:0], ge};
    end
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIV_STEPS - 1);
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = rem_n;
      quo_d = quo_n;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

// ===== src/rss_datapath.sv =====
// statistics registers, shared multiplier, divider and output register
// driven by control words from rss_sequencer; uses rss_pkg and rss_divider

module rss_datapath import rss_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_wdata_i,
  input  rss_ctrl_t              ctrl_i,
  output rss_status_t            status_o,
  input  logic                   in_valid_i,
  input  logic                   in_opcode_i,
  input  logic [DATA_W-1:0]      in_sample_i,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic [DATA_W-1:0]      out_minimum_o,
  output logic [DATA_W-1:0]      out_maximum_o,
  output logic [DATA_W-1:0]      out_mean_o,
  output logic [OUT_COUNT_W-1:0] out_count_o,
  output logic [DATA_W-1:0]      out_devsum_o,
  output logic [DATA_W-1:0]      out_variance_o
);

  localparam logic [DATA_W-1:0] SIGN_BIT = {1'b1, {(DATA_W-1){1'b0}}};

  logic                   signed_mode_q, signed_mode_d;
  logic [DATA_W-1:0]      min_q, min_d, max_q, max_d, sum_q, sum_d, devsum_q, devsum_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic                   out_valid_q, out_valid_d;

  logic                   opcode_q, opcode_d, neg_q, neg_d;
  logic [DATA_W-1:0]      sample_q, sample_d, mean_q, mean_d, dev_q, dev_d;
  logic [DATA_W-1:0]      mul_q, mul_d, sq_q, sq_d, var_q, var_d;
  logic [DATA_W-1:0]      o_min_q, o_min_d, o_max_q, o_max_d, o_mean_q, o_mean_d;
  logic [DATA_W-1:0]      o_dev_q, o_dev_d, o_var_q, o_var_d;
  logic [OUT_COUNT_W-1:0] o_cnt_q, o_cnt_d;

  logic                   div_start, div_busy;
  logic [DATA_W-1:0]      div_dividend, quotient, mean_val;
  logic                   sum_neg, count_zero, lt_min, gt_max;
  logic [31:0]            mul_a, mul_b;
  logic [DATA_W-1:0]      count_ext;

  function automatic logic [DATA_W-1:0] in_sample_sel(input logic [DATA_W-1:0] v);
    return signed_mode_q ? (v ^ SIGN_BIT) : v;
  endfunction

  rss_divider #(.COUNT_WIDTH(COUNT_WIDTH)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (count_q),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  assign count_zero = (count_q == '0);
  assign sum_neg    = signed_mode_q & sum_q[DATA_W-1];
  // signed order is unsigned order with the sign bit flipped
  assign lt_min     = (in_sample_sel(sample_q) < in_sample_sel(min_q));
  assign gt_max     = (in_sample_sel(max_q) < in_sample_sel(sample_q));
  assign mean_val   = neg_q ? DATA_W'(0) - quotient : quotient;
  assign count_ext  = DATA_W'(count_q);

  always_comb begin
    div_start    = 1'b0;
    div_dividend = devsum_q;
    case (ctrl_i.op)
      OP_MEAN_START: begin
        div_start    = 1'b1;
        div_dividend = sum_neg ? DATA_W'(0) - sum_q : sum_q;
      end
      OP_VAR_START: begin
        div_start    = 1'b1;
        div_dividend = devsum_q;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  assign mul_a = dev_q[31:0];
  assign mul_b = (ctrl_i.op == OP_MUL_LH) ? dev_q[63:32] : dev_q[31:0];

  always_comb begin
    signed_mode_d = cfg_we_i ? cfg_wdata_i : signed_mode_q;
    min_d       = min_q;
    max_d       = max_q;
    sum_d       = sum_q;
    count_d     = count_q;
    devsum_d    = devsum_q;
    opcode_d    = opcode_q;
    sample_d    = sample_q;
    neg_d       = neg_q;
    mean_d      = mean_q;
    dev_d       = dev_q;
    mul_d       = mul_q;
    sq_d        = sq_q;
    var_d       = var_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    o_min_d     = o_min_q;
    o_max_d     = o_max_q;
    o_mean_d    = o_mean_q;
    o_cnt_d     = o_cnt_q;
    o_dev_d     = o_dev_q;
    o_var_d     = o_var_q;
    case (ctrl_i.op)
      OP_ACCEPT: begin
        if (ctrl_i.accept) begin
          opcode_d = in_opcode_i;
          sample_d = in_sample_i;
        end
      end
      OP_UPDATE: begin
        if (opcode_q) begin
          min_d    = '0;
          max_d    = '0;
          sum_d    = '0;
          count_d  = '0;
          devsum_d = '0;
        end else begin
          if (count_zero || lt_min) begin
            min_d = sample_q;
          end
          if (count_zero || gt_max) begin
            max_d = sample_q;
          end
          sum_d = sum_q + sample_q;
          if (!(&count_q)) begin
            count_d = count_q + 1'b1;
          end
        end
      end
      OP_MEAN_START: begin
        neg_d = sum_neg;
      end
      OP_MEAN_TAKE: begin
        mean_d = mean_val;
        dev_d  = sample_q - mean_val;
      end
      OP_MUL_LL: begin
        mul_d = mul_a * mul_b;
      end
      OP_MUL_LH: begin
        sq_d  = mul_q;
        mul_d = mul_a * mul_b;
      end
      OP_SQ_ADD: begin
        // twice the cross term, shifted into the upper half
        sq_d = sq_q + {mul_q[30:0], 1'b0, 32'b0};
      end
      OP_DEV_ACC: begin
        devsum_d = devsum_q + sq_q;
      end
      OP_VAR_TAKE: begin
        var_d = quotient;
      end
      OP_EMIT: begin
        if (ctrl_i.emit) begin
          out_valid_d = 1'b1;
          o_min_d     = count_zero ? '0 : min_q;
          o_max_d     = count_zero ? '0 : max_q;
          o_mean_d    = count_zero ? '0 : mean_q;
          o_var_d     = count_zero ? '0 : var_q;
          o_dev_d     = devsum_q;
          o_cnt_d     = (|count_ext[DATA_W-1:OUT_COUNT_W]) ? '1
                                                           : count_ext[OUT_COUNT_W-1:0];
        end
      end
      default: begin
        mul_d = mul_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      signed_mode_q <= 1'b1;
      min_q         <= '0;
      max_q         <= '0;
      sum_q         <= '0;
      count_q       <= '0;
      devsum_q      <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      signed_mode_q <= signed_mode_d;
      min_q         <= min_d;
      max_q         <= max_d;
      sum_q         <= sum_d;
      count_q       <= count_d;
      devsum_q      <= devsum_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    opcode_q <= opcode_d;
    sample_q <= sample_d;
    neg_q    <= neg_d;
    mean_q   <= mean_d;
    dev_q    <= dev_d;
    mul_q    <= mul_d;
    sq_q     <= sq_d;
    var_q    <= var_d;
    o_min_q  <= o_min_d;
    o_max_q  <= o_max_d;
    o_mean_q <= o_mean_d;
    o_cnt_q  <= o_cnt_d;
    o_dev_q  <= o_dev_d;
    o_var_q  <= o_var_d;
  end

  assign status_o.in_valid    = in_valid_i;
  assign status_o.count_zero  = count_zero;
  assign status_o.div_busy    = div_busy;
  assign status_o.out_blocked = out_valid_q & ~out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign out_minimum_o  = o_min_q;
  assign out_maximum_o  = o_max_q;
  assign out_mean_o     = o_mean_q;
  assign out_count_o    = o_cnt_q;
  assign out_devsum_o   = o_dev_q;
  assign out_variance_o = o_var_q;

endmodule

// ===== src/rss_sequencer.sv =====
// step counter that walks the microprogram held in rss_pkg
// evaluates jump conditions from the datapath status; uses rss_pkg

module rss_sequencer import rss_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  rss_status_t status_i,
  output rss_ctrl_t   ctrl_o
);

  rss_pc_t    pc_q, pc_d;
  rss_uword_t uw;
  logic       take;

  assign uw = rss_rom(pc_q);

  always_comb begin
    case (uw.cond)
      COND_NEVER:       take = 1'b0;
      COND_ALWAYS:      take = 1'b1;
      COND_NO_INPUT:    take = ~status_i.in_valid;
      COND_COUNT_ZERO:  take = status_i.count_zero;
      COND_DIV_BUSY:    take = status_i.div_busy;
      COND_OUT_BLOCKED: take = status_i.out_blocked;
      default:          take = 1'b1;
    endcase
    pc_d = take ? uw.target : pc_q + 1'b1;

    ctrl_o.op     = uw.op;
    ctrl_o.accept = (uw.op == OP_ACCEPT) & status_i.in_valid;
    ctrl_o.emit   = (uw.op == OP_EMIT) & ~status_i.out_blocked;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_ACCEPT;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ===== src/running_sample_statistics_core.sv =====
// top level of the running sample statistics block
// uses rss_pkg, rss_if, rss_sequencer, rss_datapath and rss_divider

// Keeps min, max, wrapping sum, saturating count and a wrapping sum of squared
// deviations over 64-bit samples, one transaction at a time. opcode 0 adds the
// sample, opcode 1 clears every statistic (the mode register keeps its value).
// Each input transaction yields exactly one output transaction carrying min,
// max, integer mean, count (saturated to 32 bits), deviation total and
// variance; with an empty set min, max, mean and variance read 0. An added
// sample runs a short microprogram on the datapath: the shared radix-4
// divider makes two passes (mean, then variance), and four steps form the
// squared deviation with the 32x32 multiplier and add it to the total. The
// next input is taken once the result sits in the output register, while it
// waits to be read. cfg_wdata_i, written with cfg_we_i, selects signed (1,
// reset value) or unsigned (0) comparison and mean division; write it only
// while the block is idle.

module running_sample_statistics_core import rss_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic     cfg_wdata_i,
  rss_in_if.sink   in_i,
  rss_out_if.source out_o
);

  rss_ctrl_t   ctrl;
  rss_status_t status;
  logic [DATA_W-1:0] out_min, out_max, out_mean;

  // microprogram control
  rss_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  // statistics state, arithmetic and the output register
  rss_datapath #(.COUNT_WIDTH(COUNT_WIDTH)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .ctrl_i         (ctrl),
    .status_o       (status),
    .in_valid_i     (in_i.valid),
    .in_opcode_i    (in_i.opcode),
    .in_sample_i    (in_i.sample),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .out_minimum_o  (out_min),
    .out_maximum_o  (out_max),
    .out_mean_o     (out_mean),
    .out_count_o    (out_o.sample_count),
    .out_devsum_o   (out_o.squared_deviation_total),
    .out_variance_o (out_o.variance)
  );

  // ready only in the accept step of the program
  assign in_i.ready    = (ctrl.op == OP_ACCEPT);
  assign out_o.minimum = $signed(out_min);
  assign out_o.maximum = $signed(out_max);
  assign out_o.mean    = $signed(out_mean);

  // the divider is idle whenever a new sample can be taken
  a_ready_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !status.div_busy)
    else $error("input ready while divider busy");

  // one transaction in flight: no second accept right after one
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input accepted on consecutive cycles");

  // an empty set reports zero mean, variance and minimum
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.sample_count == '0) |->
      (out_o.mean == '0 && out_o.variance == '0 && out_o.minimum == '0))
    else $error("nonzero statistics with empty count");

endmodule
